// File: hdl/depth_fog_pixel_blend_defines.svh
// -----------------------------------------------------------------------------
// Depth fog pixel blend: assertion macros
// Shorthand for the clocked, reset-qualified properties used by the checker.
// -----------------------------------------------------------------------------
`ifndef DEPTH_FOG_PIXEL_BLEND_DEFINES_SVH
`define DEPTH_FOG_PIXEL_BLEND_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define DFOG_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
      else $error("assertion failed: %m");

// Next-cycle implication, disabled while reset is high.
`define DFOG_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> cons) \
      else $error("assertion failed: %m");

`endif

// File: hdl/dfog_pkg.sv
// -----------------------------------------------------------------------------
// Depth fog package
// Shared types and constants for the depth fog blend and its fog table builder.
// -----------------------------------------------------------------------------
`default_nettype none

package dfog_pkg;

   localparam int DEPTH_W     = 8;
   localparam int TBL_DEPTH   = 256;
   localparam int DENSITY_W   = 16;
   localparam int PIXEL_W     = 32;
   localparam int COLOR_W     = 24;

   // Fixed point used by the exponent evaluation: unsigned Q2.62
   localparam int          Q_FRAC      = 62;
   localparam logic [63:0] Q62_ONE     = 64'h4000_0000_0000_0000;

   // 255 * 255: full-scale depth squared; the Q4.12 density scale folds into the shift
   localparam logic [16:0] DEPTH_SQ    = 17'd65025;
   // floor(2^76 / 65025), split into the two 32-bit multiplier operands
   localparam logic [31:0] ZRCP_LO     = 32'h5060_7080;
   localparam logic [31:0] ZRCP_HI     = 32'h1020_3040;

   localparam logic [4:0]  TAYLOR_TERMS = 5'd16;
   localparam logic [2:0]  SQUARINGS    = 3'd6;

   // Configuration register indexes
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FOG_ENABLE  = 2'd0,
      CSR_FOG_DENSITY = 2'd1,
      CSR_FOG_COLOR   = 2'd2
   } csr_index_type;

   // Fog table builder status and table write strobe
   typedef struct packed {
      logic               busy;
      logic               wr_en;
      logic [DEPTH_W-1:0] wr_addr;
   } tbl_ctl_type;

endpackage

`default_nettype wire

// File: hdl/depth_fog_pixel_blend.sv
// Pipeline: a pixel accepted while busy is low passes the registered table read,
//   channel multiply, and sum and select stages to rsp_pixel_out with rsp_valid.
// Throughput: one pixel per clock whenever busy is low; the result path cannot stall.
// Reset (synchronous, active high) restores the register defaults and rebuilds the
//   fog table; busy stays high while the builder runs its shared 32x32 multiplier
//   and serial Taylor divider over every depth code. A density write also rebuilds it.
// -----------------------------------------------------------------------------
// Depth fog pixel blend
// Blends the RGB channels of an ARGB8888 pixel toward a fog color by an
// exponential-squared fog factor looked up by depth; alpha passes through.
// -----------------------------------------------------------------------------
`default_nettype none

module depth_fog_pixel_blend #(
   parameter int FOG_FRAC_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   // pixel request
   input  logic                            start,
   output logic                            busy,
   input  logic [dfog_pkg::PIXEL_W-1:0]    req_pixel_in,
   input  logic [dfog_pkg::DEPTH_W-1:0]    req_depth,
   // fogged pixel response
   output logic                            rsp_valid,
   output logic [dfog_pkg::PIXEL_W-1:0]    rsp_pixel_out,
   // configuration write
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [dfog_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [dfog_pkg::CSR_DATA_W-1:0] csr_data
);
   import dfog_pkg::*;

   // signed width of (fog - source) * f
   localparam int PROD_W = FOG_FRAC_BITS + 10;

   // ---------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------
   logic                  fog_enable_ff;
   logic [DENSITY_W-1:0]  fog_density_ff;
   logic [COLOR_W-1:0]    fog_color_ff;
   logic                  csr_wr;
   logic                  rebuild;

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;
   // a new density invalidates every table entry
   assign rebuild   = csr_wr && (csr_index == CSR_FOG_DENSITY);

   always_ff @(posedge clock) begin
      if (reset) begin
         fog_enable_ff  <= 1'b0;
         fog_density_ff <= DENSITY_W'(4096);
         fog_color_ff   <= '0;
      end else if (csr_wr) begin
         case (csr_index)
            CSR_FOG_ENABLE:  fog_enable_ff  <= csr_data[0];
            CSR_FOG_DENSITY: fog_density_ff <= csr_data[DENSITY_W-1:0];
            CSR_FOG_COLOR:   fog_color_ff   <= csr_data[COLOR_W-1:0];
            default: begin
               // drop writes to unmapped indexes
            end
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Fog table: f per depth code, rebuilt after reset and density writes
   // ---------------------------------------------------------------
   tbl_ctl_type               tbl_ctl;
   logic [FOG_FRAC_BITS-1:0]  tbl_wr_data;
   logic [FOG_FRAC_BITS-1:0]  tbl_rd_data;
   logic                      accept;

   dfog_table_gen #(
      .FOG_FRAC_BITS (FOG_FRAC_BITS)
   ) u_table_gen (
      .clock   (clock),
      .reset   (reset),
      .rebuild (rebuild),
      .density (fog_density_ff),
      .ctl     (tbl_ctl),
      .wr_data (tbl_wr_data)
   );

   assign busy   = tbl_ctl.busy;
   assign accept = start && !busy;

   // Stage 1 read: table data lands alongside the stage 1 registers
   dfog_ram #(
      .WIDTH (FOG_FRAC_BITS),
      .DEPTH (TBL_DEPTH)
   ) u_fog_table (
      .clock   (clock),
      .wr_en   (tbl_ctl.wr_en),
      .wr_addr (tbl_ctl.wr_addr),
      .wr_data (tbl_wr_data),
      .rd_en   (accept),
      .rd_addr (req_depth),
      .rd_data (tbl_rd_data)
   );

   // ---------------------------------------------------------------
   // Stage 1: hold the source word while the table is read
   // ---------------------------------------------------------------
   logic                s1_valid_ff;
   logic [PIXEL_W-1:0]  s1_pixel_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
      if (accept) begin
         s1_pixel_ff <= req_pixel_in;
      end
   end

   // ---------------------------------------------------------------
   // Stage 2: (fog - source) * f per channel
   // s*(2^F - f) + c*f is formed as s*2^F + (c - s)*f
   // ---------------------------------------------------------------
   logic                      s2_valid_ff;
   logic [PIXEL_W-1:0]        s2_pixel_ff;
   logic signed [PROD_W-1:0]  s2_prod_ff [3];
   logic signed [PROD_W-1:0]  prod_in [3];

   always_comb begin : chan_mul
      logic signed [8:0]        diff;
      logic signed [PROD_W-1:0] diff_x;
      logic signed [PROD_W-1:0] f_x;
      f_x = $signed(PROD_W'(tbl_rd_data));
      for (int ch = 0; ch < 3; ch++) begin
         diff        = $signed({1'b0, fog_color_ff[8*ch +: 8]})
                       - $signed({1'b0, s1_pixel_ff[8*ch +: 8]});
         diff_x      = PROD_W'(diff);
         prod_in[ch] = diff_x * f_x;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (s1_valid_ff) begin
         s2_pixel_ff <= s1_pixel_ff;
         for (int ch = 0; ch < 3; ch++) begin
            s2_prod_ff[ch] <= prod_in[ch];
         end
      end
   end

   // ---------------------------------------------------------------
   // Stage 3: add the scaled source, truncate, pick fogged or bypass word
   // ---------------------------------------------------------------
   logic                 rsp_valid_ff;
   logic [PIXEL_W-1:0]   rsp_pixel_ff;
   logic [PIXEL_W-1:0]   fogged;

   always_comb begin : chan_sum
      logic signed [PROD_W-1:0] base;
      logic signed [PROD_W-1:0] sum;
      fogged[31:24] = s2_pixel_ff[31:24];
      for (int ch = 0; ch < 3; ch++) begin
         base = $signed({2'b00, s2_pixel_ff[8*ch +: 8], {FOG_FRAC_BITS{1'b0}}});
         sum  = base + s2_prod_ff[ch];
         fogged[8*ch +: 8] = sum[FOG_FRAC_BITS +: 8];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= s2_valid_ff;
      end
      if (s2_valid_ff) begin
         // fog off: pass the source word untouched
         rsp_pixel_ff <= fog_enable_ff ? fogged : s2_pixel_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pixel_out = rsp_pixel_ff;

endmodule

`default_nettype wire

// File: hdl/dfog_ram.sv
// -----------------------------------------------------------------------------
// Depth fog RAM
// Simple dual-port RAM: one write port, one read port with registered data.
// -----------------------------------------------------------------------------
`default_nettype none

module dfog_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: hdl/dfog_table_gen.sv
// -----------------------------------------------------------------------------
// Depth fog table builder
// Sequencer that evaluates f = 1 - exp(-density * (depth/255)^2) for every
// depth code, chiefly on one shared 32x32 multiplier, and writes the fog table.
// -----------------------------------------------------------------------------
`default_nettype none

module dfog_table_gen #(
   parameter int FOG_FRAC_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           rebuild,
   input  logic [dfog_pkg::DENSITY_W-1:0] density,
   output dfog_pkg::tbl_ctl_type          ctl,
   output logic [FOG_FRAC_BITS-1:0]       wr_data
);
   import dfog_pkg::*;

   localparam int          FQ_SHIFT  = Q_FRAC - FOG_FRAC_BITS;
   localparam logic [63:0] FQ_RND    = 64'd1 << (FQ_SHIFT - 1);
   localparam int          KDIV_BITS = 4;
   localparam logic [3:0]  KDIV_LAST = 4'(64 / KDIV_BITS - 1);
   localparam logic [2:0]  MUL_LAST  = 3'd5;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQ,
      ST_NUM,
      ST_ZLO,
      ST_ZHI,
      ST_ZFIX,
      ST_HMUL,
      ST_HDIV,
      ST_HACC,
      ST_SQR,
      ST_FQ
   } state_type;

   state_type            state_ff;
   logic [DEPTH_W-1:0]   dp_ff;
   logic [15:0]          sq_ff;
   logic [31:0]          num_ff;
   logic [63:0]          z_ff;
   logic [63:0]          acc_ff;
   logic [4:0]           k_ff;
   logic [2:0]           mstep_ff;
   logic [63:0]          pp_ff;
   logic [1:0]           pp_idx_ff;
   logic [127:0]         macc_ff;
   logic [63:0]          dq_ff;
   logic [3:0]           drem_ff;
   logic [3:0]           dcnt_ff;
   logic [2:0]           sqcnt_ff;

   logic [16:0]          zlow;
   logic [16:0]          zrem;
   logic [63:0]          dq_in;
   logic [3:0]           drem_in;
   logic [63:0]          mul_a;
   logic [31:0]          op_x;
   logic [31:0]          op_y;
   logic [63:0]          pp_in;
   logic [127:0]         pp_shifted;
   logic [127:0]         macc_in;
   logic [63:0]          f_frac;
   logic [63:0]          f_round;
   logic [FOG_FRAC_BITS:0] f_q;

   // The reciprocal quotient can fall one short; the low remainder bits show it
   assign zlow = z_ff[16:0] * DEPTH_SQ;
   assign zrem = 17'd0 - zlow;

   // Division by the Taylor index, four quotient bits a cycle
   always_comb begin : kdiv_step
      logic [4:0]  t;
      logic [3:0]  r;
      logic [63:0] q;
      r = drem_ff;
      q = dq_ff;
      for (int i = 0; i < KDIV_BITS; i++) begin
         t = {r, q[63]};
         q = {q[62:0], 1'b0};
         if (t >= k_ff) begin
            t    = t - k_ff;
            q[0] = 1'b1;
         end
         r = t[3:0];
      end
      dq_in   = q;
      drem_in = r;
   end

   // Shared multiplier: one 32x32 partial product a cycle into a 128-bit sum
   always_comb begin
      mul_a = (state_ff == ST_SQR) ? acc_ff : z_ff;
      case (mstep_ff[1:0])
         2'd0: begin
            op_x = mul_a[31:0];
            op_y = acc_ff[31:0];
         end
         2'd1: begin
            op_x = mul_a[31:0];
            op_y = acc_ff[63:32];
         end
         2'd2: begin
            op_x = mul_a[63:32];
            op_y = acc_ff[31:0];
         end
         default: begin
            op_x = mul_a[63:32];
            op_y = acc_ff[63:32];
         end
      endcase
      // depth scaling: num times the reciprocal of 65025, low half then high half
      if (state_ff == ST_ZLO) begin
         op_x = num_ff;
         op_y = ZRCP_LO;
      end else if (state_ff == ST_ZHI) begin
         op_x = num_ff;
         op_y = ZRCP_HI;
      end
      pp_in = 64'(op_x) * 64'(op_y);
      case (pp_idx_ff)
         2'd0:    pp_shifted = 128'(pp_ff);
         2'd1:    pp_shifted = 128'(pp_ff) << 32;
         2'd2:    pp_shifted = 128'(pp_ff) << 32;
         default: pp_shifted = 128'(pp_ff) << 64;
      endcase
      macc_in = macc_ff + pp_shifted;
   end

   // Round the fog factor to the table width and saturate below one
   assign f_frac  = Q62_ONE - acc_ff;
   assign f_round = f_frac + FQ_RND;
   assign f_q     = f_round[FQ_SHIFT +: FOG_FRAC_BITS + 1];
   assign wr_data = f_q[FOG_FRAC_BITS] ? {FOG_FRAC_BITS{1'b1}} : f_q[FOG_FRAC_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset || rebuild) begin
         state_ff <= ST_SQ;
         dp_ff    <= '0;
         mstep_ff <= '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
            end
            ST_SQ: begin
               sq_ff    <= 16'(dp_ff) * 16'(dp_ff);
               state_ff <= ST_NUM;
            end
            ST_NUM: begin
               num_ff   <= 32'(density) * 32'(sq_ff);
               state_ff <= ST_ZLO;
            end
            ST_ZLO: begin
               pp_ff    <= pp_in;
               state_ff <= ST_ZHI;
            end
            ST_ZHI: begin
               z_ff     <= pp_in + {32'd0, pp_ff[63:32]};
               state_ff <= ST_ZFIX;
            end
            ST_ZFIX: begin
               if (zrem >= DEPTH_SQ) begin
                  z_ff <= z_ff + 64'd1;
               end
               acc_ff   <= Q62_ONE;
               k_ff     <= TAYLOR_TERMS;
               mstep_ff <= '0;
               state_ff <= ST_HMUL;
            end
            ST_HMUL, ST_SQR: begin
               mstep_ff  <= mstep_ff + 3'd1;
               pp_ff     <= pp_in;
               pp_idx_ff <= mstep_ff[1:0];
               if (mstep_ff == 3'd0) begin
                  macc_ff <= '0;
               end else begin
                  macc_ff <= macc_in;
               end
               if (mstep_ff == MUL_LAST) begin
                  mstep_ff <= '0;
                  if (state_ff == ST_HMUL) begin
                     dq_ff    <= macc_ff[Q_FRAC +: 64];
                     drem_ff  <= '0;
                     dcnt_ff  <= '0;
                     state_ff <= ST_HDIV;
                  end else begin
                     acc_ff   <= macc_ff[Q_FRAC +: 64];
                     sqcnt_ff <= sqcnt_ff + 3'd1;
                     if (sqcnt_ff == SQUARINGS - 3'd1) begin
                        state_ff <= ST_FQ;
                     end
                  end
               end
            end
            ST_HDIV: begin
               dq_ff   <= dq_in;
               drem_ff <= drem_in;
               dcnt_ff <= dcnt_ff + 4'd1;
               if (dcnt_ff == KDIV_LAST) begin
                  state_ff <= ST_HACC;
               end
            end
            ST_HACC: begin
               acc_ff <= Q62_ONE - dq_ff;
               if (k_ff == 5'd1) begin
                  sqcnt_ff <= '0;
                  state_ff <= ST_SQR;
               end else begin
                  k_ff     <= k_ff - 5'd1;
                  state_ff <= ST_HMUL;
               end
            end
            ST_FQ: begin
               if (dp_ff == DEPTH_W'(TBL_DEPTH - 1)) begin
                  state_ff <= ST_IDLE;
               end else begin
                  dp_ff    <= dp_ff + DEPTH_W'(1);
                  state_ff <= ST_SQ;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign ctl.busy    = (state_ff != ST_IDLE);
   assign ctl.wr_en   = (state_ff == ST_FQ);
   assign ctl.wr_addr = dp_ff;

endmodule

`default_nettype wire

// File: hdl/dfog_checker.sv
// -----------------------------------------------------------------------------
// Depth fog checker
// Port-level timing checks for the depth fog blend, bound to the top level.
// -----------------------------------------------------------------------------
`default_nettype none
`include "depth_fog_pixel_blend_defines.svh"

module dfog_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            start,
   input logic                            busy,
   input logic                            rsp_valid,
   input logic                            csr_valid,
   input logic                            csr_ready,
   input logic [dfog_pkg::CSR_IDX_W-1:0]  csr_index
);
   import dfog_pkg::*;

   // every accepted word comes back with rsp_valid once it leaves the pipeline
   `DFOG_ASSERT_IMP(a_rsp_follows_accept, clock, reset, start && !busy, ##3 rsp_valid)

   // no word appears on rsp_valid without a matching earlier accept
   `DFOG_ASSERT_IMP(a_rsp_has_accept, clock, reset, rsp_valid, $past(start && !busy, 3))

   // the table rebuild holds off requests right after reset
   `DFOG_ASSERT_IMP(a_busy_after_reset, clock, reset, $past(reset), busy)

   // a density write starts a table rebuild
   `DFOG_ASSERT_NEXT(a_busy_after_density, clock, reset,
      csr_valid && csr_ready && (csr_index == CSR_FOG_DENSITY), busy)

endmodule

bind depth_fog_pixel_blend dfog_checker u_dfog_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .csr_valid (csr_valid),
   .csr_ready (csr_ready),
   .csr_index (csr_index)
);

`default_nettype wire
